>>> rtl/core/rau_pkg.sv
// ----------------------------------------------------------------------------
// rau_pkg - running aggregate unit shared definitions
// widths, mode codes and sequencer states used by the aggregate unit
// ----------------------------------------------------------------------------
package rau_pkg;

  localparam int RAU_SAMPLE_BITS = 32;
  localparam int RAU_FRAC_BITS   = 16;
  localparam int RAU_RESULT_W    = 64;
  localparam int RAU_COUNT_W     = 32;
  localparam int RAU_MODE_W      = 3;

  typedef enum logic [RAU_MODE_W-1:0] {
    MODE_SUM   = 3'd0,
    MODE_AVG   = 3'd1,
    MODE_MIN   = 3'd2,
    MODE_MAX   = 3'd3,
    MODE_COUNT = 3'd4,
    MODE_DELTA = 3'd5,
    MODE_LAG   = 3'd6,
    MODE_RATIO = 3'd7
  } rau_mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_OUT
  } rau_state_t;

  // divider status back to the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } rau_div_stat_t;

endpackage

>>> rtl/core/rau_if.sv
// ----------------------------------------------------------------------------
// rau_if - channel interfaces of the running aggregate unit
// sample, result and mode-write channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface rau_sample_if import rau_pkg::*; #(
  parameter int SAMPLE_BITS = RAU_SAMPLE_BITS
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          sample_null;

  modport source (output valid, sample, sample_null, input ready);
  modport sink   (input valid, sample, sample_null, output ready);
endinterface

interface rau_result_if import rau_pkg::*; ();
  logic                           valid;
  logic                           ready;
  logic signed [RAU_RESULT_W-1:0] value_out;
  logic                           value_null;

  modport source (output valid, value_out, value_null, input ready);
  modport sink   (input valid, value_out, value_null, output ready);
endinterface

interface rau_cfg_if import rau_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [RAU_MODE_W-1:0] mode;

  modport source (output valid, mode, input ready);
  modport sink   (input valid, mode, output ready);
endinterface

>>> rtl/core/rau_div.sv
// ----------------------------------------------------------------------------
// rau_div - iterative unsigned divider
// restoring radix-2 division, one quotient bit per cycle
// ----------------------------------------------------------------------------
module rau_div import rau_pkg::*; #(
  parameter int DVD_W = RAU_RESULT_W,
  parameter int DVS_W = RAU_COUNT_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic [DVD_W-1:0] quotient,
  output rau_div_stat_t    stat
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] cnt;
  logic [DVD_W-1:0] qr;
  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] den;

  logic [DVS_W:0]   shifted;
  logic [DVS_W:0]   diff;
  logic             ge;

  assign shifted = {rem, qr[DVD_W-1]};
  assign diff    = shifted - {1'b0, den};
  assign ge      = (shifted >= {1'b0, den});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DVD_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    if (start) begin
      qr  <= dividend;
      rem <= '0;
      den <= divisor;
    end else if (busy) begin
      rem <= ge ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
      qr  <= {qr[DVD_W-2:0], ge};
    end
  end

  assign quotient  = qr;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

>>> rtl/core/running_aggregate_unit.sv
// ----------------------------------------------------------------------------
// running_aggregate_unit - running aggregate over a sample column
// sum, average, min, max, count, delta, lag and ratio with null handling
// ----------------------------------------------------------------------------
//
//  channel   dir  payload                     handshake
//  -------   ---  --------------------------  ---------------------
//  cfg       in   mode (3 bits)               valid/ready, always ready
//  samples   in   sample, sample_null         valid/ready
//  results   out  value_out, value_null       valid/ready, registered
//
//  sum, min, max, count, delta, lag and null words, and ratio words that
//  come out null: idle, exec and out states
//  avg: idle, exec, div_start, div_wait and out; ratio: idle, exec,
//  div_wait and out; shared bit-serial divider, one quotient bit per cycle
//  samples.ready is high only while the sequencer is idle
//  a finished word waits in the output register, so the next word can be
//  taken while results is stalled
//  rst is synchronous and clears the mode, the running state and all control
//
module running_aggregate_unit import rau_pkg::*; #(
  parameter int SAMPLE_BITS = RAU_SAMPLE_BITS,
  parameter int FRAC_BITS   = RAU_FRAC_BITS
) (
  input  logic          clk,
  input  logic          rst,
  rau_cfg_if.sink       cfg,
  rau_sample_if.sink    samples,
  rau_result_if.source  results
);

  localparam int RW    = RAU_RESULT_W;
  localparam int CW    = RAU_COUNT_W;
  // divider widths: avg needs a 64-bit magnitude over the count,
  // ratio needs the shifted sample magnitude over the previous sample
  localparam int DVD_W = (SAMPLE_BITS + FRAC_BITS > RW) ? SAMPLE_BITS + FRAC_BITS : RW;
  localparam int DVS_W = (SAMPLE_BITS > CW) ? SAMPLE_BITS : CW;

  localparam logic signed [RW-1:0] SUM_MAX = {1'b0, {(RW-1){1'b1}}};
  localparam logic signed [RW-1:0] SUM_MIN = {1'b1, {(RW-1){1'b0}}};

  // configuration
  rau_mode_t mode;

  // running state
  logic signed [RW-1:0]          acc_sum;
  logic signed [SAMPLE_BITS-1:0] min_seen;
  logic signed [SAMPLE_BITS-1:0] max_seen;
  logic        [CW-1:0]          item_count;
  logic signed [SAMPLE_BITS-1:0] last_sample;
  logic                          have_last;

  // sequencer
  rau_state_t state;
  rau_state_t state_next;

  // captured word and pending result
  logic signed [SAMPLE_BITS-1:0] samp;
  logic                          samp_null;
  logic signed [RW-1:0]          res;
  logic                          res_null;
  logic                          use_div;
  logic                          neg;

  // output register
  logic                 out_valid;
  logic signed [RW-1:0] out_value;
  logic                 out_null;

  // sequencer outputs
  logic in_ready;
  logic exec_en;
  logic div_start;
  logic out_load;

  // divider
  logic [DVD_W-1:0] div_dividend;
  logic [DVS_W-1:0] div_divisor;
  logic [DVD_W-1:0] div_quot;
  rau_div_stat_t    div_stat;

  // datapath helpers
  logic signed [RW:0]            sum_wide;
  logic signed [RW-1:0]          sum_sat;
  logic        [CW-1:0]          count_inc;
  logic        [SAMPLE_BITS-1:0] mag_samp;
  logic        [SAMPLE_BITS-1:0] mag_last;
  logic        [RW-1:0]          mag_acc;
  logic                          ratio_ok;
  logic                          quot_big;
  logic signed [RW-1:0]          div_result;
  logic signed [RW-1:0]          final_value;

  // ---------------------------------------------------------------- config
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_SUM;
    end else if (cfg.valid && cfg.ready) begin
      mode <= rau_mode_t'(cfg.mode);
    end
  end

  // ---------------------------------------------------------------- helpers
  // saturating add of the sign-extended sample
  assign sum_wide = (RW+1)'(acc_sum) + (RW+1)'(samp);
  always_comb begin
    if (sum_wide[RW] != sum_wide[RW-1]) begin
      sum_sat = sum_wide[RW] ? SUM_MIN : SUM_MAX;
    end else begin
      sum_sat = sum_wide[RW-1:0];
    end
  end

  // count holds at all ones
  assign count_inc = (&item_count) ? item_count : item_count + 1'b1;

  assign mag_samp = samp[SAMPLE_BITS-1] ? -samp : samp;
  assign mag_last = last_sample[SAMPLE_BITS-1] ? -last_sample : last_sample;
  assign mag_acc  = acc_sum[RW-1] ? -acc_sum : acc_sum;
  assign ratio_ok = have_last && (last_sample != '0);

  // divider operands, avg starts from the updated sum and count
  always_comb begin
    if (state == ST_DIV_START) begin
      div_dividend = DVD_W'(mag_acc);
      div_divisor  = DVS_W'(item_count);
    end else begin
      div_dividend = DVD_W'(mag_samp) << FRAC_BITS;
      div_divisor  = DVS_W'(mag_last);
    end
  end

  rau_div #(
    .DVD_W (DVD_W),
    .DVS_W (DVS_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quot),
    .stat     (div_stat)
  );

  // sign and saturate the quotient magnitude
  assign quot_big = |div_quot[DVD_W-1:RW-1];
  always_comb begin
    if (neg) begin
      div_result = quot_big ? SUM_MIN : -$signed(div_quot[RW-1:0]);
    end else begin
      div_result = quot_big ? SUM_MAX : $signed(div_quot[RW-1:0]);
    end
  end

  always_comb begin
    if (res_null) begin
      final_value = '0;
    end else if (use_div) begin
      final_value = div_result;
    end else begin
      final_value = res;
    end
  end

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (samples.valid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (samp_null) begin
          state_next = ST_OUT;
        end else if (mode == MODE_AVG) begin
          state_next = ST_DIV_START;
        end else if (mode == MODE_RATIO && ratio_ok) begin
          state_next = ST_DIV_WAIT;
        end else begin
          state_next = ST_OUT;
        end
      end
      ST_DIV_START: begin
        state_next = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_stat.done) state_next = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid || results.ready) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    exec_en   = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_EXEC: begin
        exec_en   = 1'b1;
        div_start = !samp_null && (mode == MODE_RATIO) && ratio_ok;
      end
      ST_DIV_START: begin
        div_start = 1'b1;
      end
      ST_DIV_WAIT: begin
        div_start = 1'b0;
      end
      ST_OUT: begin
        out_load = !out_valid || results.ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  assign samples.ready = in_ready;

  // capture the incoming word
  always_ff @(posedge clk) begin
    if (samples.valid && in_ready) begin
      samp      <= samples.sample;
      samp_null <= samples.sample_null;
    end
  end

  // ---------------------------------------------------------------- state update
  always_ff @(posedge clk) begin
    if (rst) begin
      acc_sum     <= '0;
      min_seen    <= '0;
      max_seen    <= '0;
      item_count  <= '0;
      last_sample <= '0;
      have_last   <= 1'b0;
    end else if (exec_en && !samp_null) begin
      case (mode)
        MODE_SUM: begin
          acc_sum <= sum_sat;
        end
        MODE_AVG: begin
          acc_sum    <= sum_sat;
          item_count <= count_inc;
        end
        MODE_MIN: begin
          if (item_count == '0 || samp < min_seen) min_seen <= samp;
          item_count <= count_inc;
        end
        MODE_MAX: begin
          if (item_count == '0 || samp > max_seen) max_seen <= samp;
          item_count <= count_inc;
        end
        MODE_COUNT: begin
          item_count <= count_inc;
        end
        MODE_DELTA, MODE_LAG, MODE_RATIO: begin
          last_sample <= samp;
          have_last   <= 1'b1;
        end
        default: begin
          have_last <= have_last;
        end
      endcase
    end
  end

  // result staging, payload only
  always_ff @(posedge clk) begin
    if (exec_en) begin
      res      <= '0;
      res_null <= samp_null;
      use_div  <= 1'b0;
      neg      <= samp[SAMPLE_BITS-1] ^ last_sample[SAMPLE_BITS-1];
      if (!samp_null) begin
        case (mode)
          MODE_SUM: begin
            res <= sum_sat;
          end
          MODE_AVG: begin
            use_div <= 1'b1;
          end
          MODE_MIN: begin
            res <= (item_count == '0 || samp < min_seen) ? RW'(samp) : RW'(min_seen);
          end
          MODE_MAX: begin
            res <= (item_count == '0 || samp > max_seen) ? RW'(samp) : RW'(max_seen);
          end
          MODE_COUNT: begin
            res <= $signed(RW'(count_inc) << FRAC_BITS);
          end
          MODE_DELTA: begin
            res      <= RW'(samp) - RW'(last_sample);
            res_null <= !have_last;
          end
          MODE_LAG: begin
            res      <= RW'(last_sample);
            res_null <= !have_last;
          end
          MODE_RATIO: begin
            use_div  <= ratio_ok;
            res_null <= !ratio_ok;
          end
          default: begin
            res_null <= 1'b1;
          end
        endcase
      end
    end else if (state == ST_DIV_START) begin
      neg <= acc_sum[RW-1];
    end
  end

  // ---------------------------------------------------------------- output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_value <= final_value;
      out_null  <= res_null;
    end
  end

  assign results.valid      = out_valid;
  assign results.value_out  = out_value;
  assign results.value_null = out_null;

  // ---------------------------------------------------------------- checks
  // divider is never restarted mid-division
  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");

  // one word at a time: no new word right after one is taken
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (samples.valid && samples.ready) |=> !samples.ready)
    else $error("second word accepted while busy");

  // a null result carries a zero value
  a_null_zero: assert property (@(posedge clk) disable iff (rst)
    (results.valid && results.value_null) |-> (results.value_out == '0))
    else $error("null result with nonzero value");

  // the count only grows
  a_count_mono: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> (item_count >= $past(item_count)))
    else $error("item count went down");

endmodule

>>> verif/tb_running_aggregate_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_running_aggregate_unit - self-checking bench for the running aggregate unit
// short directed sweep of every mode and corner, then random phases with
// sender gaps, receiver stalls and one long output hold-off; every result word
// is compared against a cycle-free aggregate predictor
// ----------------------------------------------------------------------------
module tb_running_aggregate_unit import rau_pkg::*;;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 400;
  localparam int PHASE_WORDS   = 120;
  localparam int RAND_PHASES   = 16;

  localparam logic signed [RAU_SAMPLE_BITS-1:0] S_MAX = {1'b0, {(RAU_SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [RAU_SAMPLE_BITS-1:0] S_MIN = {1'b1, {(RAU_SAMPLE_BITS-1){1'b0}}};
  localparam logic signed [RAU_RESULT_W-1:0]    R_MAX = {1'b0, {(RAU_RESULT_W-1){1'b1}}};
  localparam logic signed [RAU_RESULT_W-1:0]    R_MIN = {1'b1, {(RAU_RESULT_W-1){1'b0}}};

  typedef struct {
    logic signed [RAU_SAMPLE_BITS-1:0] sample;
    logic                              is_null;
  } sample_word_t;

  typedef struct {
    logic signed [RAU_RESULT_W-1:0] value;
    logic                           is_null;
  } agg_word_t;

  logic clk = 1'b0;
  logic rst;

  rau_cfg_if    cfg_bus ();
  rau_sample_if sample_bus ();
  rau_result_if result_bus ();

  running_aggregate_unit dut (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_bus),
    .samples (sample_bus),
    .results (result_bus)
  );

  // words waiting to be offered, and aggregate words still owed by the block
  sample_word_t pending_words[$];
  agg_word_t    agg_expected[$];

  // idle knobs, percent of cycles spent idle on each side
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  logic        hold_active    = 1'b0;
  event        hold_kick;

  int unsigned cycle_count    = 0;
  int unsigned mismatch_count = 0;

  // predictor copy of the aggregate state and the mode register
  rau_mode_t                         agg_mode;
  logic signed [RAU_RESULT_W-1:0]    acc_sum;
  logic signed [RAU_SAMPLE_BITS-1:0] min_seen;
  logic signed [RAU_SAMPLE_BITS-1:0] max_seen;
  logic        [RAU_COUNT_W-1:0]     item_count;
  logic signed [RAU_SAMPLE_BITS-1:0] last_sample;
  logic                              have_last;

  // clock, 10 ns period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  task automatic agg_clear();
    agg_mode    = MODE_SUM;
    acc_sum     = '0;
    min_seen    = '0;
    max_seen    = '0;
    item_count  = '0;
    last_sample = '0;
    have_last   = 1'b0;
  endtask

  // 64-bit add that pins at the signed limit it would cross
  function automatic logic signed [RAU_RESULT_W-1:0] sat_sum(
    logic signed [RAU_RESULT_W-1:0] a, logic signed [RAU_RESULT_W-1:0] b);
    logic signed [RAU_RESULT_W:0] wide;
    wide = {a[RAU_RESULT_W-1], a} + {b[RAU_RESULT_W-1], b};
    if (wide[RAU_RESULT_W] != wide[RAU_RESULT_W-1]) begin
      return wide[RAU_RESULT_W] ? R_MIN : R_MAX;
    end
    return wide[RAU_RESULT_W-1:0];
  endfunction

  function automatic void count_up();
    if (item_count != '1) item_count = item_count + 1'b1;
  endfunction

  // advance the running state by one word and return the aggregate word
  function automatic agg_word_t aggregate_next(sample_word_t w);
    agg_word_t                      r;
    logic signed [RAU_RESULT_W-1:0] s_wide;
    logic signed [RAU_RESULT_W-1:0] last_wide;
    r.value   = '0;
    r.is_null = 1'b0;
    // a null word passes through untouched
    if (w.is_null) begin
      r.is_null = 1'b1;
      return r;
    end
    s_wide    = w.sample;
    last_wide = last_sample;
    case (agg_mode)
      MODE_SUM: begin
        acc_sum = sat_sum(acc_sum, s_wide);
        r.value = acc_sum;
      end
      MODE_AVG: begin
        acc_sum = sat_sum(acc_sum, s_wide);
        count_up();
        r.value = acc_sum / $signed({{(RAU_RESULT_W-RAU_COUNT_W){1'b0}}, item_count});
      end
      MODE_MIN: begin
        if (item_count == 0 || w.sample < min_seen) min_seen = w.sample;
        count_up();
        r.value = min_seen;
      end
      MODE_MAX: begin
        if (item_count == 0 || w.sample > max_seen) max_seen = w.sample;
        count_up();
        r.value = max_seen;
      end
      MODE_COUNT: begin
        count_up();
        r.value = {{(RAU_RESULT_W-RAU_COUNT_W){1'b0}}, item_count} << RAU_FRAC_BITS;
      end
      default: begin
        // delta, lag and ratio all look at the previous sample
        if (!have_last) begin
          r.is_null = 1'b1;
        end else if (agg_mode == MODE_DELTA) begin
          r.value = s_wide - last_wide;
        end else if (agg_mode == MODE_LAG) begin
          r.value = last_wide;
        end else if (last_sample == 0) begin
          r.is_null = 1'b1;
        end else begin
          // shifted sample fits well inside 64 bits, so no saturation is reachable
          r.value = (s_wide <<< RAU_FRAC_BITS) / last_wide;
        end
        last_sample = w.sample;
        have_last   = 1'b1;
      end
    endcase
    return r;
  endfunction

  task automatic log_mismatch(input string msg);
    mismatch_count++;
    $display("[%0d] mismatch: %s", cycle_count, msg);
  endtask

  // ---------------------------------------------------------------------------
  // sample driver: next word only once the current one is taken
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive_samples
    sample_word_t nxt;
    if (rst) begin
      sample_bus.valid       <= 1'b0;
      sample_bus.sample      <= '0;
      sample_bus.sample_null <= 1'b0;
    end else if (!sample_bus.valid || sample_bus.ready) begin
      if (pending_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        nxt = pending_words.pop_front();
        sample_bus.valid       <= 1'b1;
        sample_bus.sample      <= nxt.sample;
        sample_bus.sample_null <= nxt.is_null;
      end else begin
        sample_bus.valid <= 1'b0;
      end
    end
  end

  // result sink: random stalls, plus the long hold-off when armed
  always @(posedge clk) begin
    if (rst) begin
      result_bus.ready <= 1'b0;
    end else begin
      result_bus.ready <= !hold_active && ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // long hold-off, counted here so the driver keeps pushing meanwhile
  initial begin
    forever begin
      @(hold_kick);
      hold_active <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_active <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: mode writes, accepted samples and result words
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watch_ports
    agg_word_t want;
    if (rst) begin
      agg_clear();
    end else begin
      // result words first, a sample taken this edge cannot already be out
      if (result_bus.valid && result_bus.ready) begin
        if (agg_expected.size() == 0) begin
          log_mismatch($sformatf("unexpected word value=%0d null=%0b",
                                 result_bus.value_out, result_bus.value_null));
        end else begin
          want = agg_expected.pop_front();
          if (result_bus.value_null !== want.is_null) begin
            log_mismatch($sformatf("null flag got %0b want %0b",
                                   result_bus.value_null, want.is_null));
          end
          if (result_bus.value_out !== want.value) begin
            log_mismatch($sformatf("value got %0d want %0d",
                                   result_bus.value_out, want.value));
          end
        end
      end
      if (cfg_bus.valid && cfg_bus.ready) agg_mode = rau_mode_t'(cfg_bus.mode);
      if (sample_bus.valid && sample_bus.ready) begin
        agg_expected.push_back(aggregate_next('{sample_bus.sample, sample_bus.sample_null}));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  task automatic queue_word(input logic signed [RAU_SAMPLE_BITS-1:0] s, input logic n);
    pending_words.push_back('{s, n});
  endtask

  // block is idle once nothing is queued, offered or owed
  task automatic wait_drained();
    while (pending_words.size() != 0 || sample_bus.valid || agg_expected.size() != 0 ||
           result_bus.valid) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // mode register write, only while the block is idle
  task automatic write_mode(input rau_mode_t m);
    wait_drained();
    cfg_bus.valid <= 1'b1;
    cfg_bus.mode  <= m;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    @(posedge clk);
  endtask

  // mostly extremes, zeros, small integers and small fixed-point values, the rest full range
  function automatic logic signed [RAU_SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return S_MAX;
      1:       return S_MIN;
      2:       return '0;
      3:       return $signed($urandom_range(0, 2000)) - 1000;
      4, 5:    return ($signed($urandom_range(0, 200)) - 100) <<< RAU_FRAC_BITS;
      default: return $urandom;
    endcase
  endfunction

  initial begin : main_seq
    rau_mode_t m;
    int        idle_kind;
    rst                    = 1'b1;
    cfg_bus.valid          = 1'b0;
    cfg_bus.mode           = '0;
    sample_bus.valid       = 1'b0;
    sample_bus.sample      = '0;
    sample_bus.sample_null = 1'b0;
    result_bus.ready       = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: sum past 32 bits, both extremes, a null word
    write_mode(MODE_SUM);
    queue_word(S_MAX, 1'b0);
    queue_word(S_MAX, 1'b0);
    queue_word(S_MIN, 1'b0);
    queue_word(S_MIN, 1'b0);
    queue_word('0, 1'b1);
    // average with a negative total, truncation toward zero
    write_mode(MODE_AVG);
    queue_word(-3, 1'b0);
    queue_word(S_MAX, 1'b0);
    queue_word(1, 1'b0);
    // min and max carry on with the count already nonzero
    write_mode(MODE_MIN);
    queue_word(5, 1'b0);
    queue_word(S_MIN, 1'b0);
    queue_word(S_MAX, 1'b1);
    write_mode(MODE_MAX);
    queue_word(S_MAX, 1'b0);
    queue_word(-1, 1'b0);
    write_mode(MODE_COUNT);
    queue_word(S_MIN, 1'b0);
    queue_word('0, 1'b1);
    // first previous-sample word is null, then full-swing deltas
    write_mode(MODE_DELTA);
    queue_word(S_MAX, 1'b0);
    queue_word(S_MIN, 1'b0);
    queue_word(S_MAX, 1'b0);
    write_mode(MODE_LAG);
    queue_word(S_MIN, 1'b1);
    queue_word(7, 1'b0);
    // ratio over a zero numerator, a zero divisor, then the extremes
    write_mode(MODE_RATIO);
    queue_word('0, 1'b0);
    queue_word(5, 1'b0);
    queue_word(S_MIN, 1'b0);
    queue_word(S_MAX, 1'b0);
    queue_word(-1, 1'b0);

    // random phases: all modes in order first, then random ones, with the
    // idle pattern rotating through none, sender, receiver and both
    for (int p = 0; p < RAND_PHASES; p++) begin
      m = (p < 8) ? rau_mode_t'(p[RAU_MODE_W-1:0]) : rau_mode_t'($urandom_range(0, 7));
      write_mode(m);
      idle_kind = p % 4;
      send_idle_pct  = (idle_kind == 1) ? 77 : (idle_kind == 3) ? 27 : 0;
      recv_stall_pct = (idle_kind == 2) ? 77 : (idle_kind == 3) ? 27 : 0;
      for (int i = 0; i < PHASE_WORDS; i++) begin
        queue_word(pick_sample(), $urandom_range(0, 9) == 0);
      end
      // one long output hold-off while the sender runs flat out
      if (p == 4) -> hold_kick;
    end

    wait_drained();
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
